/* design/rts_pkg.sv */
package rts_pkg;
	localparam int TASK_SLOTS  = 32;
	localparam int QUEUE_COUNT = 8;
	localparam int CPU_COUNT   = 8;
	localparam int SLOT_W  = $clog2(TASK_SLOTS);
	localparam int QUEUE_W = 3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_RUN  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NONE     = 2'd3;

	localparam logic [1:0] POL_NORMAL   = 2'd0;
	localparam logic [1:0] POL_FIFO     = 2'd1;
	localparam logic [1:0] POL_RR       = 2'd2;
	localparam logic [1:0] POL_DEADLINE = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic write;     // write the enqueue into the free slot
		logic scan_clr;  // clear best-so-far registers
		logic scan_step; // compare the slot under the scan pointer
		logic remove;    // clear the valid bit of the winner
		logic finish;    // load the result register
	} rts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_deq;
		logic runnable;
		logic has_free;
		logic scan_last;
		logic found;
	} rts_sts_t;
endpackage

/* design/rts_ctrl.sv */
module rts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	input  rts_pkg::rts_sts_t sts,
	output rts_pkg::rts_cmd_t cmd
);
	import rts_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DEC   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DONE  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_deq) begin
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
				end else begin
					cmd.write = sts.runnable && sts.has_free;
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_DONE;
			end
			S_DONE: begin
				cmd.remove = sts.found;
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("accept while busy");
endmodule

/* design/rts_dp.sv */
module rts_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rts_pkg::rts_cmd_t cmd,
	output rts_pkg::rts_sts_t sts,
	input  logic              kind,
	input  logic [7:0]        task_id,
	input  logic [7:0]        priority_req,
	input  logic [1:0]        policy,
	input  logic              runnable,
	input  logic [7:0]        affinity,
	input  logic [63:0]       virtual_runtime,
	input  logic [63:0]       abs_deadline,
	input  logic [2:0]        cpu,
	output logic [1:0]        status,
	output logic [7:0]        picked_id,
	output logic [1:0]        picked_policy
);
	import rts_pkg::*;

	// Slot table; valid bits are flip-flops, the payload needs no reset.
	logic [TASK_SLOTS-1:0] valid_q;
	logic [7:0]  task_q  [TASK_SLOTS];
	logic [QUEUE_W-1:0] queue_q [TASK_SLOTS];
	logic [1:0]  pol_q   [TASK_SLOTS];
	logic [7:0]  aff_q   [TASK_SLOTS];
	logic [63:0] vrt_q   [TASK_SLOTS];
	logic [63:0] dl_q    [TASK_SLOTS];
	logic [31:0] stamp_q [TASK_SLOTS];
	logic [31:0] next_stamp_q;

	// Captured item.
	logic        kind_q, run_q;
	logic [7:0]  id_in_q, aff_in_q;
	logic [QUEUE_W-1:0] qu_in_q;
	logic [1:0]  pol_in_q;
	logic [63:0] vrt_in_q, dl_in_q;
	logic [2:0]  cpu_q;

	// Scan state and best-so-far for both classes.
	logic [SLOT_W-1:0] ptr_q;
	logic        dl_has_q, rq_has_q;
	logic [SLOT_W-1:0] dl_idx_q, rq_idx_q;
	logic [63:0] dl_key_q, rq_vrt_q;
	logic [QUEUE_W-1:0] dl_qu_q, rq_qu_q;
	logic [31:0] dl_age_q, rq_age_q;
	logic        rq_rt_q;

	logic [1:0] status_q, ppol_q;
	logic [7:0] pid_q;

	// Lowest free slot.
	logic [SLOT_W-1:0] free_idx;
	logic              has_free;
	always_comb begin
		free_idx = '0;
		has_free = 1'b0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
				has_free = 1'b1;
			end
		end
	end

	logic [2:0] q_raw;
	assign q_raw = priority_req[7:5];

	// Compare of the slot under the pointer.
	logic        c_val, c_elig, c_dl, c_rt, dl_win, rq_win;
	logic [31:0] c_age;
	always_comb begin
		c_val  = valid_q[ptr_q];
		c_elig = c_val && (32'(cpu_q) < 32'(CPU_COUNT)) && aff_q[ptr_q][cpu_q];
		c_dl   = pol_q[ptr_q] == POL_DEADLINE;
		c_rt   = pol_q[ptr_q] == POL_FIFO || pol_q[ptr_q] == POL_RR;
		c_age  = next_stamp_q - stamp_q[ptr_q];
		if (dl_q[ptr_q] != dl_key_q) dl_win = dl_q[ptr_q] < dl_key_q;
		else if (queue_q[ptr_q] != dl_qu_q) dl_win = queue_q[ptr_q] < dl_qu_q;
		else dl_win = c_age > dl_age_q;
		if (queue_q[ptr_q] != rq_qu_q) rq_win = queue_q[ptr_q] < rq_qu_q;
		else if (c_rt != rq_rt_q) rq_win = c_rt;
		else if (!c_rt && vrt_q[ptr_q] != rq_vrt_q) rq_win = vrt_q[ptr_q] < rq_vrt_q;
		else rq_win = c_age > rq_age_q;
	end

	logic [SLOT_W-1:0] pick;
	assign pick = dl_has_q ? dl_idx_q : rq_idx_q;

	assign sts.is_deq    = kind_q;
	assign sts.runnable  = run_q;
	assign sts.has_free  = has_free;
	assign sts.scan_last = ptr_q == SLOT_W'(TASK_SLOTS - 1);
	assign sts.found     = dl_has_q || rq_has_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			run_q    <= runnable;
			id_in_q  <= task_id;
			aff_in_q <= affinity;
			qu_in_q  <= (32'(q_raw) > QUEUE_COUNT - 1) ? QUEUE_W'(QUEUE_COUNT - 1) : q_raw;
			pol_in_q <= policy;
			vrt_in_q <= virtual_runtime;
			dl_in_q  <= abs_deadline;
			cpu_q    <= cpu;
		end
		if (cmd.write) begin
			task_q[free_idx]  <= id_in_q;
			queue_q[free_idx] <= qu_in_q;
			pol_q[free_idx]   <= pol_in_q;
			aff_q[free_idx]   <= aff_in_q;
			vrt_q[free_idx]   <= vrt_in_q;
			dl_q[free_idx]    <= dl_in_q;
			stamp_q[free_idx] <= next_stamp_q;
		end
		if (cmd.scan_step && c_elig) begin
			if (c_dl && (!dl_has_q || dl_win)) begin
				dl_idx_q <= ptr_q;
				dl_key_q <= dl_q[ptr_q];
				dl_qu_q  <= queue_q[ptr_q];
				dl_age_q <= c_age;
			end
			if (!c_dl && (!rq_has_q || rq_win)) begin
				rq_idx_q <= ptr_q;
				rq_vrt_q <= vrt_q[ptr_q];
				rq_qu_q  <= queue_q[ptr_q];
				rq_age_q <= c_age;
				rq_rt_q  <= c_rt;
			end
		end
		if (cmd.finish) begin
			if (!kind_q) begin
				status_q <= !run_q ? ST_NOT_RUN : (!has_free ? ST_FULL : ST_OK);
				pid_q    <= '0;
				ppol_q   <= '0;
			end else if (dl_has_q || rq_has_q) begin
				status_q <= ST_OK;
				pid_q    <= task_q[pick];
				ppol_q   <= pol_q[pick];
			end else begin
				status_q <= ST_NONE;
				pid_q    <= '0;
				ppol_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			next_stamp_q <= '0;
			ptr_q        <= '0;
			dl_has_q     <= 1'b0;
			rq_has_q     <= 1'b0;
		end else begin
			if (cmd.write) begin
				valid_q[free_idx] <= 1'b1;
				next_stamp_q <= next_stamp_q + 32'd1;
			end
			if (cmd.remove) valid_q[pick] <= 1'b0;
			if (cmd.scan_clr) begin
				ptr_q    <= '0;
				dl_has_q <= 1'b0;
				rq_has_q <= 1'b0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + SLOT_W'(1);
				if (c_elig && c_dl) dl_has_q <= 1'b1;
				if (c_elig && !c_dl) rq_has_q <= 1'b1;
			end
		end
	end

	assign status        = status_q;
	assign picked_id     = pid_q;
	assign picked_policy = ppol_q;

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !valid_q[free_idx]) else $error("write into used slot");
	a_remove_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |-> valid_q[pick]) else $error("removing empty slot");
	a_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> next_stamp_q == $past(next_stamp_q) + 32'd1)
		else $error("stamp not advanced");
endmodule

/* design/ready_task_selector.sv */
// Channel | Handshake          | Fields
// input   | in_valid/in_stall  | kind task_id priority_req policy runnable affinity
//         |                    | virtual_runtime abs_deadline cpu
// output  | out_valid/out_stall| status picked_id picked_policy
//
// An enqueue result passes through S_DEC and is shown in S_OUT after the item is accepted.
// A dequeue result passes through S_DEC, S_SCAN and S_DONE before it is shown in S_OUT:
// one shared comparator visits every slot once, one slot per cycle.
// One item is in work at a time; in_stall drops the cycle after the result is taken,
// so a new item is only accepted once the last result has been taken.
// Reset empties the table and clears the insertion stamp counter at once.
// A stalled result holds its value until out_stall drops.
module ready_task_selector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  task_id,
	input  logic [7:0]  priority_req,
	input  logic [1:0]  policy,
	input  logic        runnable,
	input  logic [7:0]  affinity,
	input  logic [63:0] virtual_runtime,
	input  logic [63:0] abs_deadline,
	input  logic [2:0]  cpu,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  picked_id,
	output logic [1:0]  picked_policy
);
	import rts_pkg::*;

	rts_cmd_t cmd;
	rts_sts_t sts;

	// The controller sequences decode, slot scan and result hand-off.
	rts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .sts(sts), .cmd(cmd)
	);

	// The datapath holds the slot table and the best-so-far comparators.
	rts_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.kind(kind), .task_id(task_id), .priority_req(priority_req),
		.policy(policy), .runnable(runnable), .affinity(affinity),
		.virtual_runtime(virtual_runtime), .abs_deadline(abs_deadline),
		.cpu(cpu), .status(status), .picked_id(picked_id),
		.picked_policy(picked_policy)
	);
endmodule

/* tb/sv/tb_ready_task_selector.sv */
module tb_ready_task_selector;
	timeunit 1ns;
	timeprecision 1ps;
	import rts_pkg::*;

	localparam bit KIND_ENQ = 1'b0;
	localparam bit KIND_DEQ = 1'b1;
	// Drain margin, generously above how long a dequeue item occupies the block.
	localparam int DRAIN_CYCLES = 4 * (TASK_SLOTS + 3);
	// Longest stretch without any accepted item before the run is declared hung.
	localparam int HANG_LIMIT = 20000;
	localparam int LONG_HOLD = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [7:0]  task_id;
	logic [7:0]  priority_req;
	logic [1:0]  policy;
	logic        runnable;
	logic [7:0]  affinity;
	logic [63:0] virtual_runtime;
	logic [63:0] abs_deadline;
	logic [2:0]  cpu;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  picked_id;
	logic [1:0]  picked_policy;

	ready_task_selector dut (.*);

	// One task request as the sender offers it.
	typedef struct {
		bit        kind;
		bit [7:0]  id;
		bit [7:0]  prio;
		bit [1:0]  pol;
		bit        run;
		bit [7:0]  aff;
		bit [63:0] vrt;
		bit [63:0] dl;
		bit [2:0]  cpu;
	} task_req_t;

	// One scheduler answer.
	typedef struct {
		bit [1:0] st;
		bit [7:0] id;
		bit [1:0] pol;
	} sched_ans_t;

	// Shadow copy of the ready table.
	bit        tbl_used [TASK_SLOTS];
	bit [7:0]  tbl_id   [TASK_SLOTS];
	bit [2:0]  tbl_q    [TASK_SLOTS];
	bit [1:0]  tbl_pol  [TASK_SLOTS];
	bit [7:0]  tbl_aff  [TASK_SLOTS];
	bit [63:0] tbl_vrt  [TASK_SLOTS];
	bit [63:0] tbl_dl   [TASK_SLOTS];
	bit [31:0] tbl_stamp[TASK_SLOTS];
	bit [31:0] stamp_ctr;

	sched_ans_t pending_answers[$];
	int  mismatch_count;
	bit  failed;
	int  quiet_cycles;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_output;
	int  filled_slots;

	// Age relative to the next stamp; larger means older, with wraparound.
	function automatic bit [31:0] age(int s);
		return stamp_ctr - tbl_stamp[s];
	endfunction

	function automatic bit deadline_wins(int a, int b);
		if (tbl_dl[a] != tbl_dl[b])
			return tbl_dl[a] < tbl_dl[b];
		if (tbl_q[a] != tbl_q[b])
			return tbl_q[a] < tbl_q[b];
		return age(a) > age(b);
	endfunction

	function automatic bit queue_wins(int a, int b);
		bit rt_a;
		bit rt_b;
		rt_a = (tbl_pol[a] == POL_FIFO) || (tbl_pol[a] == POL_RR);
		rt_b = (tbl_pol[b] == POL_FIFO) || (tbl_pol[b] == POL_RR);
		if (tbl_q[a] != tbl_q[b])
			return tbl_q[a] < tbl_q[b];
		if (rt_a != rt_b)
			return rt_a;
		if (!rt_a && tbl_vrt[a] != tbl_vrt[b])
			return tbl_vrt[a] < tbl_vrt[b];
		return age(a) > age(b);
	endfunction

	// Apply one accepted request to the shadow table and return the answer.
	function automatic sched_ans_t schedule(task_req_t r);
		sched_ans_t a;
		int free_s;
		int best_dl;
		int best_rq;
		int pick;
		bit [7:0] qn;
		a = '{st: ST_OK, id: 8'd0, pol: POL_NORMAL};
		if (r.kind == KIND_ENQ) begin
			free_s = -1;
			if (!r.run) begin
				a.st = ST_NOT_RUN;
				return a;
			end
			for (int i = TASK_SLOTS - 1; i >= 0; i--)
				if (!tbl_used[i])
					free_s = i;
			if (free_s < 0) begin
				a.st = ST_FULL;
				return a;
			end
			qn = r.prio >> 5;
			if (qn > QUEUE_COUNT - 1)
				qn = 8'(QUEUE_COUNT - 1);
			tbl_used[free_s]  = 1'b1;
			tbl_id[free_s]    = r.id;
			tbl_q[free_s]     = qn[2:0];
			tbl_pol[free_s]   = r.pol;
			tbl_aff[free_s]   = r.aff;
			tbl_vrt[free_s]   = r.vrt;
			tbl_dl[free_s]    = r.dl;
			tbl_stamp[free_s] = stamp_ctr;
			stamp_ctr++;
			filled_slots++;
			return a;
		end
		best_dl = -1;
		best_rq = -1;
		if (r.cpu < CPU_COUNT) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (!tbl_used[i] || !tbl_aff[i][r.cpu])
					continue;
				if (tbl_pol[i] == POL_DEADLINE) begin
					if (best_dl < 0 || deadline_wins(i, best_dl))
						best_dl = i;
				end else if (best_rq < 0 || queue_wins(i, best_rq)) begin
					best_rq = i;
				end
			end
		end
		pick = (best_dl >= 0) ? best_dl : best_rq;
		if (pick < 0) begin
			a.st = ST_NONE;
		end else begin
			a.id  = tbl_id[pick];
			a.pol = tbl_pol[pick];
			tbl_used[pick] = 1'b0;
			filled_slots--;
		end
		return a;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset is applied once, at the start of the run.
	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver: stalls at the phase's rate, or holds off entirely when asked.
	always @(negedge clk) begin
		if (hold_output)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result checker. Each accepted result is matched against the oldest
	// expected answer; only the first few mismatches are printed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				failed = 1'b1;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item: status %0d id %0d policy %0d",
						status, picked_id, picked_policy);
			end else begin
				sched_ans_t e;
				e = pending_answers.pop_front();
				if (status !== e.st || picked_id !== e.id || picked_policy !== e.pol) begin
					failed = 1'b1;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected st %0d id %0d pol %0d, got st %0d id %0d pol %0d",
							e.st, e.id, e.pol, status, picked_id, picked_policy);
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel accepts an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Present one item at the falling edge and wait until it is accepted.
	// The predictor runs at acceptance so its order matches the block's.
	// in_valid stays high afterwards until the drain or an idle cycle of the next offer drops it.
	task automatic offer(task_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		kind            <= r.kind;
		task_id         <= r.id;
		priority_req    <= r.prio;
		policy          <= r.pol;
		runnable        <= r.run;
		affinity        <= r.aff;
		virtual_runtime <= r.vrt;
		abs_deadline    <= r.dl;
		cpu             <= r.cpu;
		do
			@(posedge clk);
		while (in_stall);
		pending_answers.push_back(schedule(r));
		@(negedge clk);
	endtask

	function automatic bit [63:0] rand64();
		case ($urandom_range(3))
			0: return 64'd0;
			1: return {32'd0, 28'd0, 4'($urandom_range(15))};
			2: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic task_req_t random_enqueue();
		task_req_t r;
		r.kind = KIND_ENQ;
		r.id   = 8'($urandom);
		r.prio = 8'($urandom);
		r.pol  = 2'($urandom);
		r.run  = ($urandom_range(19) != 0);
		// Wide masks keep most tasks eligible; some narrow ones exercise affinity.
		r.aff  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
		r.vrt  = rand64();
		r.dl   = rand64();
		r.cpu  = 3'($urandom);
		return r;
	endfunction

	function automatic task_req_t random_dequeue();
		task_req_t r;
		r = random_enqueue();
		r.kind = KIND_DEQ;
		return r;
	endfunction

	// Directed table: extremes of each field, every policy, rejection, empty
	// table, and the tie-break rules. Rows whose answer is
	// obvious carry it for a direct check as well.
	typedef struct {
		task_req_t  req;
		bit         known;
		sched_ans_t ans;
	} table_row_t;

	table_row_t directed[$];

	function automatic task_req_t mk(bit k, bit [7:0] id, bit [7:0] pr, bit [1:0] pl,
			bit rn, bit [7:0] af, bit [63:0] vr, bit [63:0] dl, bit [2:0] c);
		task_req_t r;
		r = '{kind: k, id: id, prio: pr, pol: pl, run: rn, aff: af, vrt: vr, dl: dl, cpu: c};
		return r;
	endfunction

	task automatic add_row(task_req_t r, bit known, bit [1:0] st, bit [7:0] id, bit [1:0] pl);
		table_row_t row;
		row.req = r;
		row.known = known;
		row.ans = '{st: st, id: id, pol: pl};
		directed.push_back(row);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		task_req_t r;
		sched_ans_t got;
		in_valid        = 1'b0;
		kind            = KIND_ENQ;
		task_id         = '0;
		priority_req    = '0;
		policy          = POL_NORMAL;
		runnable        = 1'b0;
		affinity        = '0;
		virtual_runtime = '0;
		abs_deadline    = '0;
		cpu             = '0;
		mismatch_count = 0;
		failed = 1'b0;
		quiet_cycles = 0;
		stamp_ctr = '0;
		filled_slots = 0;
		hold_output = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (tbl_used[i])
			tbl_used[i] = 1'b0;

		// Empty table on reset: any dequeue finds nothing.
		add_row(mk(KIND_DEQ, 0, 0, POL_NORMAL, 0, 0, 0, 0, 3'd0), 1, ST_NONE, 0, POL_NORMAL);
		add_row(mk(KIND_DEQ, 8'hFF, 8'hFF, POL_DEADLINE, 1, 8'hFF, '1, '1, 3'd7), 1,
			ST_NONE, 0, POL_NORMAL);
		// Non-runnable enqueue is rejected and leaves the table alone.
		add_row(mk(KIND_ENQ, 8'hFF, 8'hFF, POL_DEADLINE, 0, 8'hFF, '1, '1, 3'd7), 1,
			ST_NOT_RUN, 0, POL_NORMAL);
		// Normal tasks in the top queue, ordered by runtime and then age.
		add_row(mk(KIND_ENQ, 8'd10, 8'hFF, POL_NORMAL, 1, 8'hFF, '1, '0, 0), 1, ST_OK, 0, 0);
		add_row(mk(KIND_ENQ, 8'd11, 8'd224, POL_NORMAL, 1, 8'hFF, 64'd5, '0, 0), 1, ST_OK, 0, 0);
		add_row(mk(KIND_ENQ, 8'd12, 8'd230, POL_NORMAL, 1, 8'hFF, 64'd5, '0, 0), 1, ST_OK, 0, 0);
		// Round robin and fifo in a lower queue beat normal; older first.
		add_row(mk(KIND_ENQ, 8'd20, 8'd40, POL_RR, 1, 8'h80, '1, '1, 0), 1, ST_OK, 0, 0);
		add_row(mk(KIND_ENQ, 8'd21, 8'd63, POL_FIFO, 1, 8'h81, 0, 0, 0), 1, ST_OK, 0, 0);
		// Deadline tasks: tie on deadline goes to the lower queue.
		add_row(mk(KIND_ENQ, 8'd30, 8'd200, POL_DEADLINE, 1, 8'h01, 0, 64'd100, 0), 1, ST_OK, 0, 0);
		add_row(mk(KIND_ENQ, 8'd31, 8'd0, POL_DEADLINE, 1, 8'h01, 0, 64'd100, 0), 1, ST_OK, 0, 0);
		add_row(mk(KIND_ENQ, 8'd0, 8'd0, POL_DEADLINE, 1, 8'h00, 0, 0, 0), 1, ST_OK, 0, 0);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd0), 1, ST_OK, 8'd31, POL_DEADLINE);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd0), 1, ST_OK, 8'd30, POL_DEADLINE);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd7), 1, ST_OK, 8'd20, POL_RR);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd0), 1, ST_OK, 8'd21, POL_FIFO);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd3), 1, ST_OK, 8'd11, POL_NORMAL);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd3), 1, ST_OK, 8'd12, POL_NORMAL);
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd5), 1, ST_OK, 8'd10, POL_NORMAL);
		// The task with an empty mask is never eligible.
		add_row(mk(KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 3'd0), 1, ST_NONE, 0, POL_NORMAL);

		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (directed[i]) begin
			offer(directed[i].req);
			got = pending_answers[$];
			if (directed[i].known && (got.st != directed[i].ans.st
					|| got.id != directed[i].ans.id || got.pol != directed[i].ans.pol)) begin
				failed = 1'b1;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("directed row %0d: predictor disagrees with table", i);
			end
		end
		// Fill the table until every slot is used, then try once more.
		while (filled_slots < TASK_SLOTS)
			offer(random_enqueue());
		r = random_enqueue();
		r.run = 1'b1;
		offer(r);

		// Random phases with varying idling. Enqueue share varies so the
		// table swings between empty and full.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				3: begin send_idle_pct = 30; recv_stall_pct = 30; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < 260; n++) begin
				// Long receiver hold-off in the middle of the first phase; the
				// sender keeps offering so the block must stall its input.
				if (ph == 0 && n == 100)
					fork
						begin
							hold_output = 1'b1;
							repeat (LONG_HOLD) @(negedge clk);
							hold_output = 1'b0;
						end
					join_none
				if ($urandom_range(99) < ((n / 40) % 2 == 0 ? 65 : 35))
					offer(random_enqueue());
				else
					offer(random_dequeue());
			end
			// Sender pauses until every answer has come back.
			wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (!failed && pending_answers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
design/rts_pkg.sv
design/rts_ctrl.sv
design/rts_dp.sv
design/ready_task_selector.sv
tb/sv/tb_ready_task_selector.sv
